// ===== design/swpd_pkg.sv =====
`timescale 1ns / 1ps
package swpd_pkg;

   // register map, word index = paddr[4:2]
   localparam int          CSR_ADDR_BITS = 5;
   localparam int          CSR_IDX_BITS  = 3;
   localparam logic [2:0]  REG_LEVEL_FLOOR     = 3'd0;
   localparam logic [2:0]  REG_MATCH_TOLERANCE = 3'd1;
   localparam logic [2:0]  REG_BREAK_COUNT     = 3'd2;
   localparam logic [2:0]  REG_MIN_RUN         = 3'd3;
   localparam logic [2:0]  REG_MIN_LEVEL       = 3'd4;

   // fixed register field widths
   localparam int LEVEL_BITS = 12;
   localparam int BREAK_BITS = 4;
   localparam int MINRUN_BITS = 16;

   localparam logic [LEVEL_BITS-1:0]  LEVEL_FLOOR_RST     = 12'd30;
   localparam logic [LEVEL_BITS-1:0]  MATCH_TOLERANCE_RST = 12'd9;
   localparam logic [BREAK_BITS-1:0]  BREAK_COUNT_RST     = 4'd3;
   localparam logic [MINRUN_BITS-1:0] MIN_RUN_RST         = 16'd100;
   localparam logic [LEVEL_BITS-1:0]  MIN_LEVEL_RST       = 12'd1000;

   // deviation counter saturates here
   localparam logic [BREAK_BITS-1:0]  DEV_MAX = 4'd15;

   // output buffer occupancy
   typedef logic [1:0] fill_type;
   localparam fill_type FILL_EMPTY = 2'd0;
   localparam fill_type FILL_ONE   = 2'd1;
   localparam fill_type FILL_FULL  = 2'd2;

endpackage

// ===== design/swpd_if.sv =====
`timescale 1ns / 1ps
interface swpd_req_if #(
   parameter int SAMPLE_BITS = 12
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   logic                   window_end;

   modport source (output valid, sample, window_end, input ready);
   modport sink   (input valid, sample, window_end, output ready);
endinterface

interface swpd_rsp_if #(
   parameter int SAMPLE_BITS = 12,
   parameter int RUN_BITS    = 16
);
   logic                   valid;
   logic                   ready;
   logic                   is_square;
   logic [RUN_BITS-1:0]    longest_run;
   logic [SAMPLE_BITS-1:0] plateau_level;

   modport source (output valid, is_square, longest_run, plateau_level, input ready);
   modport sink   (input valid, is_square, longest_run, plateau_level, output ready);
endinterface

// ===== design/square_wave_plateau_detector.sv =====
`timescale 1ns / 1ps
// Square-wave plateau detector. Each req beat carries one ADC sample and a
// window_end flag. Samples at or below level_floor are dropped; a sample whose
// distance from the current reference is below match_tolerance lengthens the
// running plateau, otherwise a saturating deviation count rises and, once it
// passes break_count, the plateau just ended is recorded if strictly longest
// and the sample becomes the new reference. The beat flagged window_end yields
// one rsp beat (is_square, longest_run, plateau_level) and clears the window
// state; all other beats yield nothing. Throughput is one sample per cycle
// while req is ready: the whole state update is a single subtract, compare and
// increment between the state registers, and the result of a window_end beat
// is registered into a two-entry output buffer, so req stays ready while a
// result waits and only stalls when both entries are held by the sink.
// Registers are written over the csr_ APB port at byte address 4*index.
module square_wave_plateau_detector #(
   parameter int SAMPLE_BITS = 12,
   parameter int RUN_BITS    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   swpd_req_if.sink              req_bus,
   swpd_rsp_if.source            rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [4:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import swpd_pkg::*;

   // compare widths: wide enough for both the sample and the 12-bit levels
   localparam int LW = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;
   localparam int RW = (RUN_BITS > MINRUN_BITS) ? RUN_BITS : MINRUN_BITS;
   localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

   // ---------------- configuration registers ----------------
   logic [LEVEL_BITS-1:0]  level_floor_ff,     level_floor_in;
   logic [LEVEL_BITS-1:0]  match_tolerance_ff, match_tolerance_in;
   logic [BREAK_BITS-1:0]  break_count_ff,     break_count_in;
   logic [MINRUN_BITS-1:0] min_run_ff,         min_run_in;
   logic [LEVEL_BITS-1:0]  min_level_ff,       min_level_in;

   logic                    csr_wr;
   logic [CSR_IDX_BITS-1:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_BITS-1:2];

   always_comb begin
      level_floor_in     = level_floor_ff;
      match_tolerance_in = match_tolerance_ff;
      break_count_in     = break_count_ff;
      min_run_in         = min_run_ff;
      min_level_in       = min_level_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_LEVEL_FLOOR:     level_floor_in     = csr_pwdata[LEVEL_BITS-1:0];
            REG_MATCH_TOLERANCE: match_tolerance_in = csr_pwdata[LEVEL_BITS-1:0];
            REG_BREAK_COUNT:     break_count_in     = csr_pwdata[BREAK_BITS-1:0];
            REG_MIN_RUN:         min_run_in         = csr_pwdata[MINRUN_BITS-1:0];
            REG_MIN_LEVEL:       min_level_in       = csr_pwdata[LEVEL_BITS-1:0];
            default: ;  // unmapped word: write dropped
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_LEVEL_FLOOR:     csr_prdata = {{(32-LEVEL_BITS){1'b0}}, level_floor_ff};
         REG_MATCH_TOLERANCE: csr_prdata = {{(32-LEVEL_BITS){1'b0}}, match_tolerance_ff};
         REG_BREAK_COUNT:     csr_prdata = {{(32-BREAK_BITS){1'b0}}, break_count_ff};
         REG_MIN_RUN:         csr_prdata = {{(32-MINRUN_BITS){1'b0}}, min_run_ff};
         REG_MIN_LEVEL:       csr_prdata = {{(32-LEVEL_BITS){1'b0}}, min_level_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_floor_ff     <= LEVEL_FLOOR_RST;
         match_tolerance_ff <= MATCH_TOLERANCE_RST;
         break_count_ff     <= BREAK_COUNT_RST;
         min_run_ff         <= MIN_RUN_RST;
         min_level_ff       <= MIN_LEVEL_RST;
      end else begin
         level_floor_ff     <= level_floor_in;
         match_tolerance_ff <= match_tolerance_in;
         break_count_ff     <= break_count_in;
         min_run_ff         <= min_run_in;
         min_level_ff       <= min_level_in;
      end
   end

   // ---------------- window state ----------------
   logic [SAMPLE_BITS-1:0] ref_ff,  ref_in;
   logic [RUN_BITS-1:0]    run_ff,  run_in;
   logic [RUN_BITS-1:0]    best_ff, best_in;
   logic [SAMPLE_BITS-1:0] blvl_ff, blvl_in;
   logic [BREAK_BITS-1:0]  dev_ff,  dev_in;

   logic                   req_fire;
   logic [LW-1:0]          smp_w, ref_w;
   logic [LW-1:0]          diff;
   logic                   above_floor, matched, broken;
   logic [BREAK_BITS-1:0]  dev_inc;

   // result being formed this cycle
   logic                   res_sq;
   logic [RUN_BITS-1:0]    res_run;
   logic [SAMPLE_BITS-1:0] res_lvl;

   assign req_fire = req_bus.valid && req_bus.ready;

   assign smp_w       = LW'(req_bus.sample);
   assign ref_w       = LW'(ref_ff);
   assign diff        = (smp_w > ref_w) ? (smp_w - ref_w) : (ref_w - smp_w);
   assign above_floor = smp_w > LW'(level_floor_ff);
   assign matched     = diff < LW'(match_tolerance_ff);
   assign dev_inc     = (dev_ff < DEV_MAX) ? (dev_ff + 1'b1) : dev_ff;
   assign broken      = dev_inc > break_count_ff;

   always_comb begin
      ref_in  = ref_ff;
      run_in  = run_ff;
      best_in = best_ff;
      blvl_in = blvl_ff;
      dev_in  = dev_ff;
      if (req_fire && above_floor) begin
         if (matched) begin
            if (run_ff < RUN_MAX) run_in = run_ff + 1'b1;
            dev_in = '0;
         end else begin
            dev_in = dev_inc;
            if (broken) begin
               if (best_ff < run_ff) begin
                  best_in = run_ff;
                  blvl_in = ref_ff;
               end
               run_in = '0;
               ref_in = req_bus.sample;
            end
         end
      end
      // verdict uses the best plateau after this sample; running one not counted
      res_run = best_in;
      res_lvl = blvl_in;
      res_sq  = (RW'(best_in) > RW'(min_run_ff)) && (LW'(blvl_in) > LW'(min_level_ff));
      if (req_fire && req_bus.window_end) begin
         ref_in  = '0;
         run_in  = '0;
         best_in = '0;
         blvl_in = '0;
         dev_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff  <= '0;
         run_ff  <= '0;
         best_ff <= '0;
         blvl_ff <= '0;
         dev_ff  <= '0;
      end else begin
         ref_ff  <= ref_in;
         run_ff  <= run_in;
         best_ff <= best_in;
         blvl_ff <= blvl_in;
         dev_ff  <= dev_in;
      end
   end

   // ---------------- two-entry result buffer ----------------
   // entry 0 drives rsp; entry 1 catches a result while entry 0 is stalled
   logic                   push, pop;
   fill_type               fill_ff, fill_in;
   logic                   sq0_ff, sq0_in, sq1_ff, sq1_in;
   logic [RUN_BITS-1:0]    run0_ff, run0_in, run1_ff, run1_in;
   logic [SAMPLE_BITS-1:0] lvl0_ff, lvl0_in, lvl1_ff, lvl1_in;

   assign push = req_fire && req_bus.window_end;
   assign pop  = rsp_bus.valid && rsp_bus.ready;

   assign req_bus.ready         = (fill_ff != FILL_FULL);
   assign rsp_bus.valid         = (fill_ff != FILL_EMPTY);
   assign rsp_bus.is_square     = sq0_ff;
   assign rsp_bus.longest_run   = run0_ff;
   assign rsp_bus.plateau_level = lvl0_ff;

   always_comb begin
      fill_in = fill_ff;
      sq0_in  = sq0_ff;
      run0_in = run0_ff;
      lvl0_in = lvl0_ff;
      sq1_in  = sq1_ff;
      run1_in = run1_ff;
      lvl1_in = lvl1_ff;
      if (pop) begin
         // shift entry 1 forward
         sq0_in  = sq1_ff;
         run0_in = run1_ff;
         lvl0_in = lvl1_ff;
      end
      if (push) begin
         if (fill_ff == FILL_EMPTY || (fill_ff == FILL_ONE && pop)) begin
            sq0_in  = res_sq;
            run0_in = res_run;
            lvl0_in = res_lvl;
         end else begin
            sq1_in  = res_sq;
            run1_in = res_run;
            lvl1_in = res_lvl;
         end
      end
      if (push && !pop)      fill_in = fill_ff + 1'b1;
      else if (pop && !push) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= FILL_EMPTY;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      sq0_ff  <= sq0_in;
      run0_ff <= run0_in;
      lvl0_ff <= lvl0_in;
      sq1_ff  <= sq1_in;
      run1_ff <= run1_in;
      lvl1_ff <= lvl1_in;
   end

   // ---------------- checks ----------------
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff == FILL_EMPTY || fill_ff == FILL_ONE || fill_ff == FILL_FULL)
      else $error("result buffer over-filled");

   a_window_clear: assert property (@(posedge clock) disable iff (reset)
      push |=> (run_ff == '0 && best_ff == '0 && dev_ff == '0 && ref_ff == '0))
      else $error("window state not cleared after window end");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> ($stable(run_ff) && $stable(best_ff) && $stable(dev_ff)))
      else $error("window state moved without a sample");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (fill_ff == $past(fill_ff) - 2'd1))
      else $error("result buffer count wrong after drain");

   a_best_monotone: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_bus.window_end) |=> (best_ff >= $past(best_ff)))
      else $error("longest plateau shrank within a window");

endmodule

// ===== verif/swpd_verdict_checker.sv =====
`timescale 1ns / 1ps
// Watches the req, rsp and csr traffic of the plateau detector, keeps its own
// copy of the window state and register values, and checks every rsp beat.
module swpd_verdict_checker (
   input  logic        clock,
   input  logic        reset,
   swpd_req_if         req_mon,
   swpd_rsp_if         rsp_mon,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending_verdicts
);
   import swpd_pkg::*;

   localparam int RUN_BITS = MINRUN_BITS;
   localparam logic [RUN_BITS-1:0] RUN_MAX = '1;

   typedef struct packed {
      logic                  is_square;
      logic [RUN_BITS-1:0]   longest_run;
      logic [LEVEL_BITS-1:0] plateau_level;
   } verdict_type;

   // register copies
   logic [LEVEL_BITS-1:0]  floor_q;
   logic [LEVEL_BITS-1:0]  tol_q;
   logic [BREAK_BITS-1:0]  break_q;
   logic [MINRUN_BITS-1:0] min_run_q;
   logic [LEVEL_BITS-1:0]  min_level_q;

   // window state
   logic [LEVEL_BITS-1:0]  ref_level;
   logic [RUN_BITS-1:0]    run_len;
   logic [RUN_BITS-1:0]    best_run;
   logic [LEVEL_BITS-1:0]  best_level;
   logic [BREAK_BITS-1:0]  dev_count;

   verdict_type verdict_queue[$];

   function void clear_window();
      ref_level  = '0;
      run_len    = '0;
      best_run   = '0;
      best_level = '0;
      dev_count  = '0;
   endfunction

   function void take_sample(input logic [LEVEL_BITS-1:0] s, input logic last);
      logic [LEVEL_BITS-1:0] abs_diff;
      verdict_type           v;
      if (s > floor_q) begin
         abs_diff = (s > ref_level) ? s - ref_level : ref_level - s;
         if (abs_diff < tol_q) begin
            if (run_len != RUN_MAX) run_len = run_len + 1'b1;
            dev_count = '0;
         end else begin
            if (dev_count != DEV_MAX) dev_count = dev_count + 1'b1;
            // count is kept, so further deviations keep restarting the plateau
            if (dev_count > break_q) begin
               if (run_len > best_run) begin
                  best_run   = run_len;
                  best_level = ref_level;
               end
               run_len   = '0;
               ref_level = s;
            end
         end
      end
      if (last) begin
         v.is_square     = (best_run > min_run_q) && (best_level > min_level_q);
         v.longest_run   = best_run;
         v.plateau_level = best_level;
         verdict_queue.push_back(v);
         clear_window();
      end
   endfunction

   function void check_verdict();
      verdict_type want;
      fail_count++;
      if (verdict_queue.size() == 0) begin
         if (fail_count <= 10)
            $display("%0t swpd_chk: rsp beat with none expected: sq=%0b run=%0d lvl=%0d",
                     $realtime, rsp_mon.is_square, rsp_mon.longest_run,
                     rsp_mon.plateau_level);
         return;
      end
      want = verdict_queue.pop_front();
      if (want.is_square !== rsp_mon.is_square || want.longest_run !== rsp_mon.longest_run ||
          want.plateau_level !== rsp_mon.plateau_level) begin
         if (fail_count <= 10)
            $display({"%0t swpd_chk: mismatch sq exp %0b got %0b, ",
                      "run exp %0d got %0d, lvl exp %0d got %0d"},
                     $realtime, want.is_square, rsp_mon.is_square, want.longest_run,
                     rsp_mon.longest_run, want.plateau_level, rsp_mon.plateau_level);
      end else begin
         fail_count--;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         floor_q     = LEVEL_FLOOR_RST;
         tol_q       = MATCH_TOLERANCE_RST;
         break_q     = BREAK_COUNT_RST;
         min_run_q   = MIN_RUN_RST;
         min_level_q = MIN_LEVEL_RST;
         clear_window();
         verdict_queue.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_LEVEL_FLOOR:     floor_q     = csr_pwdata[LEVEL_BITS-1:0];
               REG_MATCH_TOLERANCE: tol_q       = csr_pwdata[LEVEL_BITS-1:0];
               REG_BREAK_COUNT:     break_q     = csr_pwdata[BREAK_BITS-1:0];
               REG_MIN_RUN:         min_run_q   = csr_pwdata[MINRUN_BITS-1:0];
               REG_MIN_LEVEL:       min_level_q = csr_pwdata[LEVEL_BITS-1:0];
               default: ;
            endcase
         end
         // a rsp beat always belongs to an earlier req beat, so check first
         if (rsp_mon.valid && rsp_mon.ready) check_verdict();
         if (req_mon.valid && req_mon.ready) take_sample(req_mon.sample, req_mon.window_end);
      end
      pending_verdicts = verdict_queue.size();
   end

endmodule

// ===== verif/tb_square_wave_plateau_detector.sv =====
`timescale 1ns / 1ps
module tb_square_wave_plateau_detector;
   import swpd_pkg::*;

   // index beyond the register map; writes there must be dropped
   localparam logic [2:0] REG_UNUSED = 3'd7;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int pending_verdicts;

   // idling controls, changed per phase
   int req_max_gap   = 5;
   int rsp_max_stall = 5;
   bit rsp_hold      = 1'b0;

   // register values as last written, used only to shape the stimulus
   int cfg_floor = 30;
   int cfg_tol   = 9;
   int phase_beats;

   swpd_req_if req_bus ();
   swpd_rsp_if rsp_bus ();

   square_wave_plateau_detector u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   swpd_verdict_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_pready       (csr_pready),
      .fail_count       (fail_count),
      .pending_verdicts (pending_verdicts)
   );

   always #5 clock = ~clock;

   // Hard stop. The slowest legal run (at most ~2100 beats, each with worst gaps
   // and stalls, plus the long hold-off) ends well before it.
   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

   // rsp sink: random stall before each beat, plus a long hold-off on demand.
   // Called at negedges only, so ready gets one update per step.
   initial begin : rsp_sink
      int stall;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = $urandom_range(0, rsp_max_stall);
         if (stall > 0 || rsp_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
            while (rsp_hold) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   // One req beat. Entered at a negedge, returns at the negedge after the
   // handshake, with valid still high so back-to-back beats need no toggle.
   task automatic send_beat(input logic [11:0] s, input logic last);
      int gap;
      gap = $urandom_range(0, req_max_gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.sample     <= s;
      req_bus.window_end <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      phase_beats++;
   endtask

   // Drop valid, wait for every verdict, then let the registered output drain.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_verdicts != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // APB write: setup then access, then idle so writes never abut.
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_config(input int floor_v, input int tol_v, input int brk_v,
                              input int mrun_v, input int mlevel_v);
      settle();
      csr_write(REG_LEVEL_FLOOR, floor_v);
      csr_write(REG_MATCH_TOLERANCE, tol_v);
      csr_write(REG_BREAK_COUNT, brk_v);
      csr_write(REG_MIN_RUN, mrun_v);
      csr_write(REG_MIN_LEVEL, mlevel_v);
      cfg_floor = floor_v;
      cfg_tol   = tol_v;
   endtask

   // 1 in 8 low extreme, 1 in 8 high extreme, otherwise a typical value
   function automatic int pick_reg(input int hi, input int typ_lo, input int typ_hi);
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return 0;
      if (r == 1) return hi;
      return $urandom_range(typ_lo, typ_hi);
   endfunction

   // One measurement window: mostly plateaus with jitter inside tolerance,
   // odd dips to the floor and bursts of stray samples between plateaus;
   // now and then a window of plain noise. Last beat carries window_end.
   task automatic send_window();
      logic [11:0] beats[$];
      int          lo;
      int          lvl;
      int          jmax;
      int          n;
      lo   = (cfg_floor < 4095) ? cfg_floor + 1 : 4095;
      jmax = (cfg_tol > 0) ? ((cfg_tol - 1 < 40) ? cfg_tol - 1 : 40) : 0;
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 30)) beats.push_back(12'($urandom_range(0, 4095)));
      end else begin
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 7) == 0)
               lvl = $urandom_range(0, 1) ? lo : 4095;
            else
               lvl = $urandom_range(lo, 4095);
            repeat ($urandom_range(1, 20)) begin
               if ($urandom_range(0, 15) == 0)
                  beats.push_back(12'($urandom_range(0, cfg_floor)));
               n = lvl + int'($urandom_range(0, 2 * jmax)) - jmax;
               n = (n < 0) ? 0 : (n > 4095) ? 4095 : n;
               beats.push_back(12'(n));
            end
            repeat ($urandom_range(0, 6)) beats.push_back(12'($urandom_range(0, 4095)));
         end
      end
      foreach (beats[i]) send_beat(beats[i], i == beats.size() - 1);
   endtask

   initial begin : stimulus
      reset              = 1'b1;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      req_bus.valid      = 1'b0;
      req_bus.sample     = '0;
      req_bus.window_end = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed, reset register values (floor 30, tol 9, break 3) ---
      // zero and the floor itself are both ignored
      send_beat(12'd0, 1'b0);
      send_beat(12'd30, 1'b0);
      // full scale: fourth deviation from the zero reference ends an empty
      // plateau (not recorded, not strictly longer); fifth beat matches
      repeat (5) send_beat(12'd4095, 1'b0);
      send_beat(12'd4087, 1'b0);   // just inside tolerance
      send_beat(12'd4086, 1'b0);   // exactly at tolerance counts as deviation
      repeat (3) send_beat(12'd4095, 1'b0);
      // lowest accepted level breaks and records the full-scale plateau
      repeat (5) send_beat(12'd31, 1'b0);
      send_beat(12'd0, 1'b1);      // ignored beat still closes the window
      send_beat(12'd4095, 1'b1);   // window of a single beat

      // --- every register at its low extreme; unmapped index is dropped ---
      load_config(0, 0, 0, 0, 0);
      csr_write(REG_UNUSED, 32'hFFFF_FFFF);
      send_beat(12'd0, 1'b0);
      send_beat(12'd4095, 1'b0);
      send_beat(12'd4095, 1'b1);

      // --- high extremes: every sample ignored, verdict can never be set ---
      load_config(4095, 4095, 15, 65535, 4095);
      send_beat(12'd4095, 1'b0);
      send_beat(12'd4095, 1'b1);

      // --- break 15: deviation count pins at 15 and no plateau ever ends ---
      load_config(30, 9, 15, 0, 0);
      for (int i = 0; i < 20; i++) send_beat(i[0] ? 12'd3500 : 12'd500, 1'b0);
      send_beat(12'd500, 1'b1);

      // --- random phases, each under a fresh register set ---
      for (int ph = 0; ph < 8; ph++) begin
         load_config(pick_reg(4095, 0, 300), pick_reg(4095, 1, 24), pick_reg(15, 1, 6),
                     pick_reg(65535, 1, 30), pick_reg(4095, 1, 2500));
         req_max_gap   = (ph % 3 == 0) ? 0 : 5;
         rsp_max_stall = (ph % 3 == 0) ? 0 : 5;
         phase_beats   = 0;
         for (int w = 0; phase_beats < 110 && w < 40; w++) send_window();
      end

      // --- back-pressure: every beat closes a window while rsp is held off,
      // so the output buffer fills and req must stall ---
      load_config(0, 9, 0, 0, 0);
      req_max_gap   = 0;
      rsp_max_stall = 5;
      fork
         begin
            rsp_hold = 1'b1;
            repeat (200) @(posedge clock);
            rsp_hold = 1'b0;
         end
         repeat (40) send_beat(12'($urandom_range(0, 4095)), 1'b1);
      join

      settle();
      repeat (10) @(negedge clock);
      if (fail_count == 0 && pending_verdicts == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
